// ----- rtl/core/mfi_pkg.sv -----
// Shared types, constants and the tanh table for the MLP forward inference unit.
package mfi_pkg;

  // Network geometry
  localparam int MAX_WIDTH  = 16;
  localparam int MAX_LAYERS = 4;
  localparam int FRAC_BITS  = 12;
  localparam int IDX_W      = $clog2(MAX_WIDTH);
  localparam int LAYER_W    = $clog2(MAX_LAYERS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int WADDR_W    = LAYER_W + 2 * IDX_W;
  localparam int WDEPTH     = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = 40;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_LAYERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEURONS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT  = 2'd3;

  // Item kinds
  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Input item
  typedef struct packed {
    logic                    kind;
    logic [1:0]              layer_sel;
    logic [3:0]              neuron_sel;
    logic [3:0]              position;
    logic signed [15:0]      value;
    logic                    last;
  } mfi_in_t;

  // Result item
  typedef struct packed {
    logic [3:0]              out_index;
    logic signed [15:0]      out_value;
    logic                    out_last;
  } mfi_out_t;

  // Per-term control traveling with one multiply-accumulate
  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

  // Tanh table: round(4096 * tanh(k/64)) for k = 0..512, 13 bits each
  localparam int TANH_DEPTH = 513;
  localparam int TANH_BITS  = 13;
  typedef logic [TANH_DEPTH*TANH_BITS-1:0] tanh_rom_t;

  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

  // Q2.62 product, used only while building the table
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Shift-subtract long division, used only while building the table
  function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quotient known to fit in 14 bits
  function automatic logic [13:0] short_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [13:0] q;
    rem = n;
    q   = '0;
    for (int b = 13; b >= 0; b--) begin
      if (rem >= (d << b)) begin
        rem  = rem - (d << b);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-1/32) by series, then tanh = (1 - t) / (1 + t) with t = exp(-2x)
  function automatic tanh_rom_t tanh_build();
    tanh_rom_t   rom;
    logic [63:0] term;
    logic [63:0] c;
    logic [63:0] t;
    logic [63:0] num;
    logic [63:0] den;
    logic [13:0] q;
    rom  = '0;
    term = Q62_ONE;
    c    = Q62_ONE;
    t    = Q62_ONE;
    for (int n = 1; n <= 20; n++) begin
      term = long_div(term, 64'(32 * n));
      if ((n % 2) == 1) c = c - term;
      else              c = c + term;
    end
    for (int k = 0; k < TANH_DEPTH; k++) begin
      num = (Q62_ONE - t) >> 14;
      den = (Q62_ONE + t) >> 14;
      q   = short_div((num << 13) + den, den << 1);
      rom[k*TANH_BITS +: TANH_BITS] = q[TANH_BITS-1:0];
      t   = mul_q62(t, c);
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = tanh_build();

  // Odd-symmetric table tanh on a Q4.12 value
  function automatic logic signed [15:0] tanh_q(input logic signed [15:0] v);
    logic [9:0]            idx;
    logic [9:0]            mag;
    logic [TANH_BITS-1:0]  e;
    idx = v[15:6];
    mag = idx[9] ? (~idx + 10'd1) : idx;
    e   = TANH_ROM[int'(mag)*TANH_BITS +: TANH_BITS];
    return idx[9] ? -{3'd0, e} : {3'd0, e};
  endfunction

endpackage

// ----- rtl/core/mfi_wram.sv -----
// Weight store: single write port, single registered read port.
module mfi_wram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [mfi_pkg::WADDR_W-1:0] waddr,
  input  logic [mfi_pkg::DATA_W-1:0]  wdata,
  input  logic                        re,
  input  logic [mfi_pkg::WADDR_W-1:0] raddr,
  output logic [mfi_pkg::DATA_W-1:0]  rdata
);
  import mfi_pkg::*;

  logic [DATA_W-1:0] mem [WDEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/mfi_mac.sv -----
// Shared multiply-accumulate unit with floor shift and 16-bit saturation.
module mfi_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  mfi_pkg::mac_ctl_t                 ctl,
  input  logic signed [mfi_pkg::DATA_W-1:0] a,
  input  logic signed [mfi_pkg::DATA_W-1:0] b,
  output logic signed [mfi_pkg::DATA_W-1:0] sum_sat
);
  import mfi_pkg::*;

  localparam int SH_W = ACC_W - FRAC_BITS;

  mac_ctl_t                 prod_ctl;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [SH_W-1:0]   shifted;
  logic                     ovf;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
    end else begin
      prod_ctl <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // Accumulate stage; the first term of a neuron restarts the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (prod_ctl.valid) begin
      acc <= prod_ctl.first ? prod_ext : acc + prod_ext;
    end
  end

  // Arithmetic shift (floor) and clamp to the 16-bit range
  assign shifted = acc[ACC_W-1:FRAC_BITS];
  assign ovf     = (shifted[SH_W-1:DATA_W-1] != {(SH_W-DATA_W+1){shifted[SH_W-1]}});

  always_comb begin
    if (ovf) begin
      sum_sat = shifted[SH_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sum_sat = shifted[DATA_W-1:0];
    end
  end

endmodule

// ----- rtl/core/mlp_forward_inference_unit.sv -----
// Top level of the MLP forward inference unit: item sequencer, vectors and outputs.
//
// Usage: items enter on in_valid/in_ready with an mfi_in_t payload. A weight item
// writes one entry of the weight store; a sample item writes one input entry, and
// a sample marked last starts a forward pass. Results leave on out_valid/out_ready,
// one mfi_out_t per output neuron, the final one carrying out_last.
// Weight items and sample items without last do not start a pass; in_ready stays high.
// A pass runs every multiply-accumulate on one shared MAC, one term per cycle.
// After its terms are issued, each neuron passes through MAC pipeline drain,
// saturate and write-back; each output neuron then waits in its result register
// until it is taken. in_ready stays low for the whole pass.
// A stalled receiver holds the pass at the waiting result; nothing is dropped.
// Reset clears the sequencer and sets the registers to hidden_layers 1,
// neurons_per_layer 16, input_count 16, output_count 4. Weights, samples and
// activations are undefined until written. Configuration writes go through
// cfg_we/cfg_index/cfg_data, land at once, and belong only to idle periods.
module mlp_forward_inference_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mfi_pkg::mfi_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mfi_pkg::mfi_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [mfi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mfi_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SAT   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]         state;
  logic [1:0]         hidden_layers;
  logic [CNT_W-1:0]   neurons_per_layer;
  logic [CNT_W-1:0]   input_count;
  logic [CNT_W-1:0]   output_count;

  logic [1:0]         h_eff;
  logic [CNT_W-1:0]   nn_eff;
  logic [CNT_W-1:0]   ni_eff;
  logic [CNT_W-1:0]   no_eff;

  logic [LAYER_W-1:0] layer;
  logic [IDX_W-1:0]   neuron;
  logic [IDX_W-1:0]   term;
  logic               dcnt;
  logic               cur_bank;
  logic               wbank;

  logic [CNT_W-1:0]   len;
  logic [CNT_W-1:0]   ncount;
  logic               term_last;
  logic               neuron_last;
  logic               layer_out;

  logic signed [DATA_W-1:0] in_vec [MAX_WIDTH];
  logic signed [DATA_W-1:0] act [2][MAX_WIDTH];
  logic signed [DATA_W-1:0] src_q;
  logic signed [DATA_W-1:0] sat_q;
  logic signed [DATA_W-1:0] wb_value;
  logic signed [DATA_W-1:0] mac_sat;
  logic [DATA_W-1:0]        wram_rdata;

  mac_ctl_t           iss_ctl;
  mac_ctl_t           ctl_q;
  logic               in_acc;
  logic               wr_weight;
  logic [WADDR_W-1:0] rd_addr;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign wr_weight = in_acc && (in_data.kind == KIND_WEIGHT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hidden_layers     <= 2'd1;
      neurons_per_layer <= 5'd16;
      input_count       <= 5'd16;
      output_count      <= 5'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIDDEN_LAYERS: hidden_layers     <= cfg_data[1:0];
        REG_NEURONS:       neurons_per_layer <= cfg_data;
        REG_INPUT_COUNT:   input_count       <= cfg_data;
        REG_OUTPUT_COUNT:  output_count      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counts clamped at use
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (v > CNT_W'(MAX_WIDTH)) return CNT_W'(MAX_WIDTH);
    return v;
  endfunction

  assign h_eff  = (hidden_layers == 2'd0) ? 2'd1 : hidden_layers;
  assign nn_eff = clamp_cnt(neurons_per_layer);
  assign ni_eff = clamp_cnt(input_count);
  assign no_eff = clamp_cnt(output_count);

  // Loop bounds of the current neuron and layer
  assign layer_out   = (layer == h_eff);
  assign len         = (layer == '0) ? ni_eff : nn_eff;
  assign ncount      = layer_out ? no_eff : nn_eff;
  assign term_last   = ({1'b0, term} == len - CNT_W'(1));
  assign neuron_last = ({1'b0, neuron} == ncount - CNT_W'(1));
  assign wbank       = (layer == '0) ? 1'b0 : ~cur_bank;

  // Term issue: weight address and source operand
  assign rd_addr       = {layer, neuron, term};
  assign iss_ctl.valid = (state == S_ISSUE);
  assign iss_ctl.first = (term == '0);

  mfi_wram u_wram (
    .clk   (clk),
    .we    (wr_weight),
    .waddr ({in_data.layer_sel, in_data.neuron_sel, in_data.position}),
    .wdata (in_data.value),
    .re    (iss_ctl.valid),
    .raddr (rd_addr),
    .rdata (wram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= iss_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (iss_ctl.valid) begin
      src_q <= (layer == '0) ? in_vec[term] : act[cur_bank][term];
    end
  end

  mfi_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_q),
    .a       (wram_rdata),
    .b       (src_q),
    .sum_sat (mac_sat)
  );

  // Input vector
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.kind == KIND_SAMPLE)) begin
      in_vec[in_data.position] <= in_data.value;
    end
  end

  // Saturated sum, tanh on layer zero
  always_ff @(posedge clk) begin
    if (state == S_SAT) begin
      sat_q <= mac_sat;
    end
  end

  assign wb_value = (layer == '0) ? tanh_q(sat_q) : sat_q;

  // Activation banks
  always_ff @(posedge clk) begin
    if ((state == S_WB) && !layer_out) begin
      act[wbank][neuron] <= wb_value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if ((state == S_WB) && layer_out) begin
      out_data.out_index <= neuron;
      out_data.out_value <= wb_value;
      out_data.out_last  <= neuron_last;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      layer    <= '0;
      neuron   <= '0;
      term     <= '0;
      dcnt     <= 1'b0;
      cur_bank <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_data.kind == KIND_SAMPLE) && in_data.last) begin
            layer    <= '0;
            neuron   <= '0;
            term     <= '0;
            cur_bank <= 1'b0;
            state    <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (term_last) begin
            dcnt  <= 1'b0;
            state <= S_DRAIN;
          end else begin
            term <= term + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (dcnt) begin
            state <= S_SAT;
          end else begin
            dcnt <= 1'b1;
          end
        end
        S_SAT: begin
          state <= S_WB;
        end
        S_WB: begin
          term <= '0;
          if (layer_out) begin
            state <= S_OUT;
          end else if (neuron_last) begin
            neuron   <= '0;
            layer    <= layer + LAYER_W'(1);
            cur_bank <= wbank;
            state    <= S_ISSUE;
          end else begin
            neuron <= neuron + IDX_W'(1);
            state  <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (neuron_last) begin
              state <= S_IDLE;
            end else begin
              neuron <= neuron + IDX_W'(1);
              state  <= S_ISSUE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/mlp_forward_inference_unit_test.sv -----
// Self-checking testbench for the MLP forward inference unit with its own network predictor.
module mlp_forward_inference_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mfi_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT_NS    = 10_000_000;
  localparam int RANDOM_ITEMS  = 130;
  localparam int TANH_ENTRIES  = 513;
  localparam logic [63:0] UNIT_Q62 = 64'h4000_0000_0000_0000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  mfi_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mfi_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Network copy held by the predictor
  logic signed [15:0] wt_mem  [MAX_LAYERS][MAX_WIDTH][MAX_WIDTH];
  logic signed [15:0] smp_mem [MAX_WIDTH];
  logic signed [15:0] dot_src [MAX_WIDTH];
  int                 tanh_tab [TANH_ENTRIES];
  logic [1:0]         cfg_hidden  = 2'd1;
  logic [4:0]         cfg_neurons = 5'd16;
  logic [4:0]         cfg_inputs  = 5'd16;
  logic [4:0]         cfg_outputs = 5'd4;

  // Which entries the stimulus has written so far
  bit wt_set  [MAX_LAYERS][MAX_WIDTH][MAX_WIDTH];
  bit smp_set [MAX_WIDTH];

  mfi_in_t  pending_items[$];
  mfi_out_t expected_results[$];
  int       items_queued   = 0;
  int       items_accepted = 0;
  int       rand_items     = 0;
  int       error_count    = 0;
  int       in_gap         = 0;
  int       out_wait       = 0;
  bit       steady_flow    = 1'b0;

  mlp_forward_inference_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tanh(k/64) in Q.12 from t = exp(-k/32), all in exact integer steps
  task automatic build_tanh_table();
    logic [63:0]  term;
    logic [63:0]  step;
    logic [63:0]  t;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  dv;
    logic [127:0] prod;
    term = UNIT_Q62;
    step = UNIT_Q62;
    t    = UNIT_Q62;
    for (int n = 1; n <= 20; n++) begin
      dv   = 64'(32 * n);
      term = term / dv;
      if (n % 2 == 1) step = step - term;
      else step = step + term;
    end
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      num = (UNIT_Q62 - t) >> 14;
      den = (UNIT_Q62 + t) >> 14;
      tanh_tab[k] = int'((num * 64'd8192 + den) / (den * 64'd2));
      prod = 128'(t) * 128'(step);
      t    = prod[125:62];
    end
  endtask

  function automatic int clamp_cnt(input int raw, input int hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Effective layer count and widths after clamping
  task automatic get_shape(output int h, output int nn, output int ni, output int no);
    h  = clamp_cnt(int'(cfg_hidden), MAX_LAYERS - 1);
    nn = clamp_cnt(int'(cfg_neurons), MAX_WIDTH);
    ni = clamp_cnt(int'(cfg_inputs), MAX_WIDTH);
    no = clamp_cnt(int'(cfg_outputs), MAX_WIDTH);
  endtask

  // One neuron: exact dot product over dot_src, floor shift, clip to 16 bits
  function automatic logic signed [15:0] neuron_out(input int lyr, input int nrn, input int len);
    longint acc;
    acc = 0;
    for (int j = 0; j < len; j++)
      acc += longint'(wt_mem[lyr][nrn][j]) * longint'(dot_src[j]);
    acc = acc >>> FRAC_BITS;
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    return 16'(acc);
  endfunction

  function automatic logic signed [15:0] tanh_lut(input logic signed [15:0] v);
    int k;
    k = int'(v) >>> 6;
    if (k >= 0) return 16'(tanh_tab[k]);
    return 16'(-tanh_tab[-k]);
  endfunction

  // Apply one accepted item; a sample marked last runs the whole network
  task automatic predict_item(input mfi_in_t it);
    logic signed [15:0] cur [MAX_WIDTH];
    logic signed [15:0] nxt [MAX_WIDTH];
    int                 h;
    int                 nn;
    int                 ni;
    int                 no;
    mfi_out_t           res;
    if (it.kind == KIND_WEIGHT) begin
      wt_mem[it.layer_sel][it.neuron_sel][it.position] = it.value;
    end else begin
      smp_mem[it.position] = it.value;
      if (it.last) begin
        get_shape(h, nn, ni, no);
        dot_src = smp_mem;
        for (int n = 0; n < nn; n++) cur[n] = tanh_lut(neuron_out(0, n, ni));
        for (int l = 1; l < h; l++) begin
          dot_src = cur;
          for (int n = 0; n < nn; n++) nxt[n] = neuron_out(l, n, nn);
          cur = nxt;
        end
        dot_src = cur;
        for (int n = 0; n < no; n++) begin
          res.out_index = 4'(n);
          res.out_value = neuron_out(h, n, nn);
          res.out_last  = (n == no - 1);
          expected_results.push_back(res);
        end
      end
    end
  endtask

  task automatic check_result(input mfi_out_t got);
    mfi_out_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      $display("%0t: unexpected result: expected none, got index %0d value %0d last %0b",
               $time, got.out_index, got.out_value, got.out_last);
    end else begin
      want = expected_results.pop_front();
      if (got.out_index !== want.out_index) begin
        error_count++;
        $display("%0t: out_index expected %0d got %0d", $time, want.out_index, got.out_index);
      end
      if (got.out_value !== want.out_value) begin
        error_count++;
        $display("%0t: out_value expected %0d got %0d", $time, want.out_value, got.out_value);
      end
      if (got.out_last !== want.out_last) begin
        error_count++;
        $display("%0t: out_last expected %0b got %0b", $time, want.out_last, got.out_last);
      end
    end
  endtask

  // Driver: presents queued items, random gap after each accepted item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_data);
        items_accepted++;
        in_gap = steady_flow ? 0 : $urandom_range(0, 3);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result, then holds ready low for a random stall
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        out_wait = steady_flow ? 0 : $urandom_range(0, 3);
      end else if (out_valid && out_wait > 0) begin
        out_wait--;
      end
      out_ready <= (out_wait == 0);
    end
  end

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  task automatic push_item(input mfi_in_t it);
    pending_items.push_back(it);
    items_queued++;
    rand_items++;
    if (it.kind == KIND_WEIGHT) wt_set[it.layer_sel][it.neuron_sel][it.position] = 1'b1;
    else smp_set[it.position] = 1'b1;
  endtask

  task automatic push_weight(input int lyr, input int nrn, input int pos,
                             input logic signed [15:0] val);
    mfi_in_t it;
    it.kind       = KIND_WEIGHT;
    it.layer_sel  = 2'(lyr);
    it.neuron_sel = 4'(nrn);
    it.position   = 4'(pos);
    it.value      = val;
    it.last       = 1'($urandom);
    push_item(it);
  endtask

  task automatic push_sample(input int pos, input logic signed [15:0] val, input bit last);
    mfi_in_t it;
    it.kind       = KIND_SAMPLE;
    it.layer_sel  = 2'($urandom);
    it.neuron_sel = 4'($urandom);
    it.position   = 4'(pos);
    it.value      = val;
    it.last       = last;
    push_item(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_HIDDEN_LAYERS: cfg_hidden  = val[1:0];
      REG_NEURONS:       cfg_neurons = val;
      REG_INPUT_COUNT:   cfg_inputs  = val;
      REG_OUTPUT_COUNT:  cfg_outputs = val;
      default: ;
    endcase
  endtask

  task automatic set_network(input int hid, input int nrn, input int inp, input int outp);
    write_reg(REG_HIDDEN_LAYERS, 5'(hid));
    write_reg(REG_NEURONS, 5'(nrn));
    write_reg(REG_INPUT_COUNT, 5'(inp));
    write_reg(REG_OUTPUT_COUNT, 5'(outp));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every item is taken and every result is back
  task automatic wait_idle();
    while (items_accepted != items_queued || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One inference: load missing or refreshed weights, stray items, inputs, then last
  task automatic run_pass(input int refresh_pct);
    int h;
    int nn;
    int ni;
    int no;
    int rows;
    int cols;
    bit full;
    get_shape(h, nn, ni, no);
    for (int lyr = 0; lyr <= h; lyr++) begin
      rows = (lyr == h) ? no : nn;
      cols = (lyr == 0) ? ni : nn;
      for (int n = 0; n < rows; n++)
        for (int j = 0; j < cols; j++)
          if (!wt_set[lyr][n][j] || $urandom_range(0, 99) < refresh_pct)
            push_weight(lyr, n, j, rand_value());
    end
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1))
        push_weight($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 15),
                    rand_value());
      else
        push_sample($urandom_range(0, 15), rand_value(), 1'b0);
    end
    // full input vector most times, a partial update otherwise
    full = ($urandom_range(0, 3) != 0);
    for (int j = 0; j < ni; j++)
      if (!smp_set[j] || full || $urandom_range(0, 1)) push_sample(j, rand_value(), 1'b0);
    push_sample($urandom_range(0, 15), rand_value(), 1'b1);
  endtask

  task automatic run_phase(input int hid, input int nrn, input int inp, input int outp,
                           input int passes, input int refresh_pct);
    wait_idle();
    steady_flow = ($urandom_range(0, 3) == 0);
    set_network(hid, nrn, inp, outp);
    repeat (passes) run_pass(refresh_pct);
  endtask

  initial begin
    build_tanh_table();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: two inputs, two tanh neurons, two outputs
    set_network(1, 2, 2, 2);
    push_weight(0, 0, 0, 16'h7fff);
    push_weight(0, 0, 1, 16'h7fff);
    push_weight(0, 1, 0, 16'h8000);
    push_weight(0, 1, 1, 16'h1000);
    push_weight(1, 0, 0, 16'h1000);
    push_weight(1, 0, 1, 16'h1000);
    push_weight(1, 1, 0, 16'h8000);
    push_weight(1, 1, 1, 16'h7fff);
    // top corner of the store, not read with this shape
    push_weight(3, 15, 15, 16'h5a5a);
    // sample past input_count is stored only
    push_sample(15, 16'h1234, 1'b0);
    // full scale: sums clip high and low, tanh at both ends
    push_sample(0, 16'h7fff, 1'b0);
    push_sample(1, 16'h7fff, 1'b1);
    // mid range: tanh in its curved part, negative index
    push_sample(0, 16'h0800, 1'b0);
    push_sample(1, 16'hff00, 1'b1);
    // small negative sum: floor shift lands on index -1
    push_sample(0, 16'h0001, 1'b0);
    push_sample(1, 16'hffff, 1'b1);
    push_sample(0, 16'h0000, 1'b0);
    push_sample(1, 16'h0000, 1'b1);
    push_sample(0, 16'h8000, 1'b0);
    push_sample(1, 16'h8000, 1'b1);

    // Random passes over several shapes, extremes and out-of-range counts included
    rand_items = 0;
    run_phase(2, 3, 3, 2, 1, 25);
    run_phase(3, 2, 4, 3, 1, 25);
    run_phase(1, 16, 1, 1, 1, 5);
    // hidden field keeps its low two bits; zero widths clamp up, wide ones clamp down
    run_phase(6, 0, 20, 17, 1, 5);
    run_phase(0, 0, 0, 0, 2, 50);
    run_phase(1, 31, 0, 1, 2, 5);
    while (rand_items < RANDOM_ITEMS)
      run_phase($urandom_range(1, 3), $urandom_range(1, 5), $urandom_range(1, 5),
                $urandom_range(1, 5), $urandom_range(2, 4), 30);

    wait_idle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

// ----- mlp_forward_inference_unit.f -----
rtl/core/mfi_pkg.sv
rtl/core/mfi_wram.sv
rtl/core/mfi_mac.sv
rtl/core/mlp_forward_inference_unit.sv
tb/mlp_forward_inference_unit_test.sv
